// ===== design/xyy_to_srgb_pixel_convert_defines.svh =====
// Assertion macros shared by the xyY to sRGB converter sources.
`ifndef XYY_TO_SRGB_PIXEL_CONVERT_DEFINES_SVH
`define XYY_TO_SRGB_PIXEL_CONVERT_DEFINES_SVH
`ifndef SYNTHESIS
// Clocked check with reset as disable condition and an explicit message.
`define XYY2RGB_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Same check with a generic message.
`define XYY2RGB_CHECK(name, clk, rst, prop) \
   `XYY2RGB_ASSERT(name, clk, rst, prop, "xyy2rgb check failed")
`else
`define XYY2RGB_ASSERT(name, clk, rst, prop, msg)
`define XYY2RGB_CHECK(name, clk, rst, prop)
`endif
`endif

// ===== design/xyy2rgb_pkg.sv =====
// Shared constants, types and constant tables of the xyY to sRGB converter.
package xyy2rgb_pkg;

   localparam int FRAC_BITS      = 16;
   localparam int GAMMA_SEGMENTS = 256;

   localparam int IN_W  = 18;
   localparam int OUT_W = 20;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 1;

   // Dividend magnitude and signed XYZ widths.
   localparam int NUM_W   = 2 * IN_W + 1;
   localparam int XYZ_W   = NUM_W + 1;
   localparam int SPLIT_W = (XYZ_W + 1) / 2;
   localparam int HI_W    = XYZ_W - SPLIT_W;
   localparam int COEF_W  = FRAC_BITS + 3;
   localparam int PROD_W  = SPLIT_W + 1 + COEF_W;
   localparam int SUM_W   = PROD_W + 2;
   localparam int ACC_W   = SUM_W + SPLIT_W + 1;

   // Gamma stage widths.
   localparam int GT_W    = FRAC_BITS + 2;
   localparam int GIDX_W  = $clog2(GAMMA_SEGMENTS + 1);
   localparam int POS_W   = FRAC_BITS + GIDX_W;
   localparam int C1292_W = FRAC_BITS + 5;
   localparam int LIN_W   = OUT_W + C1292_W;
   localparam int IP_W    = GT_W + FRAC_BITS + 2;

   localparam longint ONE_FX  = longint'(1) << FRAC_BITS;
   localparam longint RND_FX  = longint'(1) << (FRAC_BITS - 1);
   localparam longint OUT_MAX = (longint'(1) << (OUT_W - 1)) - 1;
   localparam longint OUT_MIN = -(longint'(1) << (OUT_W - 1));
   localparam longint C1292   = ((longint'(1292) << FRAC_BITS) + 50) / 100;
   localparam longint GAM_THR = ((longint'(31308) << FRAC_BITS) + 5000000) / 10000000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SOURCE_IS_XYZ = 1'b0,
      CSR_APPLY_GAMMA   = 1'b1
   } csr_index_type;

   // Pipeline advance and the valid bit of the transaction entering a unit.
   typedef struct packed {
      logic advance;
      logic valid;
   } stage_ctl_type;

   // Per-transaction data that rides alongside the divider.
   typedef struct packed {
      logic            fault;
      logic            gamma_en;
      logic            neg_z;
      logic [IN_W-1:0] lum;
   } side_type;

   typedef struct packed {
      logic fault;
      logic gamma_en;
   } flags_type;

   typedef logic signed [COEF_W-1:0] coef_row_type [3];
   typedef logic signed [GT_W-1:0]   gamma_table_type [0:GAMMA_SEGMENTS];

   // Ten-thousandths to fixed point, rounding half away from zero.
   function automatic logic signed [COEF_W-1:0] coef_fx(input longint e4);
      longint mag;
      longint r;
      mag = (e4 < 0) ? -e4 : e4;
      r   = ((mag << FRAC_BITS) + 5000) / 10000;
      return COEF_W'((e4 < 0) ? -r : r);
   endfunction

   localparam logic signed [COEF_W-1:0] COEF_FX [3][3] = '{
      '{coef_fx(32406), coef_fx(-15372), coef_fx(-4986)},
      '{coef_fx(-9689), coef_fx(18758),  coef_fx(415)},
      '{coef_fx(557),   coef_fx(-2040),  coef_fx(10570)}
   };

   // Largest r in [0, 2^21] with r^k <= v, k being 2 or 3.
   function automatic longint unsigned root_floor(input longint unsigned v, input int k);
      longint unsigned lo;
      longint unsigned hi;
      longint unsigned mid;
      longint unsigned p;
      lo = 0;
      hi = longint'(1) << 21;
      while (lo < hi) begin
         mid = (lo + hi + 1) >> 1;
         p   = mid * mid;
         if (k == 3) begin
            p = p * mid;
         end
         if (p <= v) begin
            lo = mid;
         end else begin
            hi = mid - 1;
         end
      end
      return lo;
   endfunction

   // Transfer curve samples: 1.055 * (i/N)^(5/12) - 0.055.
   function automatic gamma_table_type build_gamma_table();
      gamma_table_type tab;
      longint unsigned u;
      longint unsigned q;
      longint unsigned r4;
      longint unsigned r6;
      longint unsigned p;
      longint c1055;
      longint c055;
      c1055 = ((longint'(1055) << FRAC_BITS) + 500) / 1000;
      c055  = ((longint'(55) << FRAC_BITS) + 500) / 1000;
      for (int i = 0; i <= GAMMA_SEGMENTS; i++) begin
         u  = (longint'(i) << 20) / GAMMA_SEGMENTS;
         q  = root_floor(u << 20, 2);
         r4 = root_floor(q << 20, 2);
         r6 = root_floor(q << 40, 3);
         p  = (r4 * r6 + (longint'(1) << 19)) >> 20;
         tab[i] = GT_W'(longint'((p * c1055 + (longint'(1) << 19)) >> 20) - c055);
      end
      return tab;
   endfunction

   localparam gamma_table_type GAMMA_TABLE = build_gamma_table();

endpackage

// ===== design/xyy2rgb_if.sv =====
// Request and response channel interfaces of the xyY to sRGB converter.
interface xyy2rgb_req_if
   import xyy2rgb_pkg::*;
;
   logic            valid;
   logic            ready;
   logic [IN_W-1:0] comp_a;
   logic [IN_W-1:0] comp_b;
   logic [IN_W-1:0] comp_c;

   modport source (output valid, output comp_a, output comp_b, output comp_c, input ready);
   modport sink   (input valid, input comp_a, input comp_b, input comp_c, output ready);
endinterface

interface xyy2rgb_rsp_if
   import xyy2rgb_pkg::*;
;
   logic                    valid;
   logic                    ready;
   logic signed [OUT_W-1:0] red_out;
   logic signed [OUT_W-1:0] green_out;
   logic signed [OUT_W-1:0] blue_out;
   logic                    divide_fault;

   modport source (output valid, output red_out, output green_out, output blue_out,
                   output divide_fault, input ready);
   modport sink   (input valid, input red_out, input green_out, input blue_out,
                   input divide_fault, output ready);
endinterface

// ===== design/xyy2rgb_div.sv =====
// Pipelined restoring divider: two dividends over one divisor, one quotient bit per stage.
`include "xyy_to_srgb_pixel_convert_defines.svh"
module xyy2rgb_div
   import xyy2rgb_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  stage_ctl_type    ctl,
   input  logic [NUM_W-1:0] num_x,
   input  logic [NUM_W-1:0] num_z,
   input  logic [IN_W-1:0]  divisor,
   input  side_type         side_in,
   output logic             valid_out,
   output logic [NUM_W-1:0] quot_x,
   output logic [NUM_W-1:0] quot_z,
   output side_type         side_out
);

   logic             valid_ff [NUM_W];
   logic [NUM_W-1:0] numx_ff  [NUM_W];
   logic [NUM_W-1:0] numz_ff  [NUM_W];
   logic [IN_W-1:0]  remx_ff  [NUM_W];
   logic [IN_W-1:0]  remz_ff  [NUM_W];
   logic [IN_W-1:0]  div_ff   [NUM_W];
   side_type         side_ff  [NUM_W];

   logic             valid_in [NUM_W];
   logic [NUM_W-1:0] numx_in  [NUM_W];
   logic [NUM_W-1:0] numz_in  [NUM_W];
   logic [IN_W-1:0]  remx_in  [NUM_W];
   logic [IN_W-1:0]  remz_in  [NUM_W];
   logic [IN_W-1:0]  div_in   [NUM_W];
   side_type         side_in_q [NUM_W];

   // Each stage shifts one dividend bit into the partial remainder and
   // shifts the quotient bit into the low end of the dividend register.
   always_comb begin
      logic [NUM_W-1:0] nx;
      logic [NUM_W-1:0] nz;
      logic [IN_W-1:0]  rx;
      logic [IN_W-1:0]  rz;
      logic [IN_W:0]    tx;
      logic [IN_W:0]    tz;
      logic [IN_W-1:0]  d;
      logic             gx;
      logic             gz;
      for (int k = 0; k < NUM_W; k++) begin
         if (k == 0) begin
            nx = num_x;
            nz = num_z;
            rx = '0;
            rz = '0;
            d  = divisor;
            valid_in[k]  = ctl.valid;
            side_in_q[k] = side_in;
         end else begin
            nx = numx_ff[k-1];
            nz = numz_ff[k-1];
            rx = remx_ff[k-1];
            rz = remz_ff[k-1];
            d  = div_ff[k-1];
            valid_in[k]  = valid_ff[k-1];
            side_in_q[k] = side_ff[k-1];
         end
         tx = {rx, nx[NUM_W-1]};
         tz = {rz, nz[NUM_W-1]};
         gx = (tx >= {1'b0, d});
         gz = (tz >= {1'b0, d});
         remx_in[k] = gx ? IN_W'(tx - {1'b0, d}) : tx[IN_W-1:0];
         remz_in[k] = gz ? IN_W'(tz - {1'b0, d}) : tz[IN_W-1:0];
         numx_in[k] = {nx[NUM_W-2:0], gx};
         numz_in[k] = {nz[NUM_W-2:0], gz};
         div_in[k]  = d;
      end
   end

   // Stage registers; valid bits are control state and clear on reset.
   always_ff @(posedge clock) begin
      for (int k = 0; k < NUM_W; k++) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (ctl.advance) begin
            valid_ff[k] <= valid_in[k];
         end
         if (ctl.advance) begin
            numx_ff[k] <= numx_in[k];
            numz_ff[k] <= numz_in[k];
            remx_ff[k] <= remx_in[k];
            remz_ff[k] <= remz_in[k];
            div_ff[k]  <= div_in[k];
            side_ff[k] <= side_in_q[k];
         end
      end
   end

   assign valid_out = valid_ff[NUM_W-1];
   assign quot_x    = numx_ff[NUM_W-1];
   assign quot_z    = numz_ff[NUM_W-1];
   assign side_out  = side_ff[NUM_W-1];

   // A finished division with a nonzero divisor leaves remainders below it.
   `XYY2RGB_ASSERT(a_div_rem_x, clock, reset, valid_ff[NUM_W-1] && !side_ff[NUM_W-1].fault |-> remx_ff[NUM_W-1] < div_ff[NUM_W-1], "X remainder not below divisor")
   `XYY2RGB_CHECK(a_div_rem_z, clock, reset, valid_ff[NUM_W-1] && !side_ff[NUM_W-1].fault |-> remz_ff[NUM_W-1] < div_ff[NUM_W-1])

endmodule

// ===== design/xyy2rgb_mtx.sv =====
// XYZ to linear RGB matrix: split products, partial sums, rounding and saturation.
module xyy2rgb_mtx
   import xyy2rgb_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  stage_ctl_type           ctl,
   input  logic [NUM_W-1:0]        quot_x,
   input  logic [NUM_W-1:0]        quot_z,
   input  side_type                side_in,
   output logic                    valid_out,
   output logic signed [OUT_W-1:0] lin_out [3],
   output flags_type               flags_out
);

   localparam logic signed [ACC_W-1:0] ACC_RND = ACC_W'(RND_FX);
   localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(OUT_MAX);
   localparam logic signed [ACC_W-1:0] ACC_MIN = ACC_W'(OUT_MIN);

   logic      valid_ff [4];
   flags_type flags_ff [4];

   logic signed [XYZ_W-1:0]  xyz_ff [3];
   logic signed [XYZ_W-1:0]  xyz_in [3];
   logic signed [PROD_W-1:0] plo_ff [3][3];
   logic signed [PROD_W-1:0] phi_ff [3][3];
   logic signed [PROD_W-1:0] plo_in [3][3];
   logic signed [PROD_W-1:0] phi_in [3][3];
   logic signed [SUM_W-1:0]  slo_ff [3];
   logic signed [SUM_W-1:0]  shi_ff [3];
   logic signed [SUM_W-1:0]  slo_in [3];
   logic signed [SUM_W-1:0]  shi_in [3];
   logic signed [OUT_W-1:0]  lin_ff [3];
   logic signed [OUT_W-1:0]  lin_in [3];

   // Form signed XYZ: quotients, the luminance, and the sign of Z.
   always_comb begin
      logic signed [XYZ_W-1:0] zpos;
      zpos      = signed'({1'b0, quot_z});
      xyz_in[0] = signed'({1'b0, quot_x});
      xyz_in[1] = signed'(XYZ_W'(side_in.lum));
      xyz_in[2] = side_in.neg_z ? -zpos : zpos;
   end

   // Each component is cut into an unsigned low half and a signed high half.
   always_comb begin
      logic signed [SPLIT_W:0] lo;
      logic signed [HI_W-1:0]  hi;
      for (int r = 0; r < 3; r++) begin
         for (int k = 0; k < 3; k++) begin
            lo = signed'({1'b0, xyz_ff[k][SPLIT_W-1:0]});
            hi = xyz_ff[k][XYZ_W-1:SPLIT_W];
            plo_in[r][k] = lo * COEF_FX[r][k];
            phi_in[r][k] = hi * COEF_FX[r][k];
         end
      end
   end

   // Row sums of the low and high partial products.
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         slo_in[r] = SUM_W'(plo_ff[r][0]) + SUM_W'(plo_ff[r][1]) + SUM_W'(plo_ff[r][2]);
         shi_in[r] = SUM_W'(phi_ff[r][0]) + SUM_W'(phi_ff[r][1]) + SUM_W'(phi_ff[r][2]);
      end
   end

   // Recombine, round half up to the output scale and saturate.
   always_comb begin
      logic signed [ACC_W-1:0] acc;
      logic signed [ACC_W-1:0] sh;
      for (int r = 0; r < 3; r++) begin
         acc = (ACC_W'(shi_ff[r]) <<< SPLIT_W) + ACC_W'(slo_ff[r]) + ACC_RND;
         sh  = acc >>> FRAC_BITS;
         if (sh > ACC_MAX) begin
            lin_in[r] = OUT_W'(ACC_MAX);
         end else if (sh < ACC_MIN) begin
            lin_in[r] = OUT_W'(ACC_MIN);
         end else begin
            lin_in[r] = sh[OUT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < 4; s++) begin
            valid_ff[s] <= 1'b0;
         end
      end else if (ctl.advance) begin
         valid_ff[0] <= ctl.valid;
         for (int s = 1; s < 4; s++) begin
            valid_ff[s] <= valid_ff[s-1];
         end
      end
      if (ctl.advance) begin
         flags_ff[0] <= '{fault: side_in.fault, gamma_en: side_in.gamma_en};
         for (int s = 1; s < 4; s++) begin
            flags_ff[s] <= flags_ff[s-1];
         end
         xyz_ff <= xyz_in;
         plo_ff <= plo_in;
         phi_ff <= phi_in;
         slo_ff <= slo_in;
         shi_ff <= shi_in;
         lin_ff <= lin_in;
      end
   end

   assign valid_out = valid_ff[3];
   assign flags_out = flags_ff[3];
   assign lin_out   = lin_ff;

endmodule

// ===== design/xyy2rgb_gam.sv =====
// sRGB transfer curve: table lookup, interpolation, linear segment and output register.
`include "xyy_to_srgb_pixel_convert_defines.svh"
module xyy2rgb_gam
   import xyy2rgb_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  stage_ctl_type           ctl,
   input  logic signed [OUT_W-1:0] lin_in [3],
   input  flags_type               flags_in,
   output logic                    valid_out,
   output logic signed [OUT_W-1:0] rgb_out [3],
   output logic                    fault_out
);

   localparam logic signed [OUT_W-1:0]   THR_S    = OUT_W'(GAM_THR);
   localparam logic signed [OUT_W-1:0]   ONE_S    = OUT_W'(ONE_FX);
   localparam logic signed [C1292_W-1:0] C1292_S  = C1292_W'(C1292);
   localparam logic signed [LIN_W-1:0]   LIN_RND  = LIN_W'(RND_FX);
   localparam logic signed [LIN_W-1:0]   LIN_MAX  = LIN_W'(OUT_MAX);
   localparam logic signed [LIN_W-1:0]   LIN_MIN  = LIN_W'(OUT_MIN);
   localparam logic signed [IP_W-1:0]    IP_RND   = IP_W'(RND_FX);
   localparam logic [GIDX_W-1:0]         LAST_IDX = GIDX_W'(GAMMA_SEGMENTS);

   logic      valid_ff [3];
   flags_type flags_ff [3];

   // First stage: table samples, fraction, linear-segment product.
   logic signed [GT_W-1:0]    t0_ff   [3];
   logic signed [GT_W-1:0]    t1_ff   [3];
   logic [FRAC_BITS-1:0]      frac_ff [3];
   logic                      below_ff [3];
   logic signed [LIN_W-1:0]   lprod_ff [3];
   logic signed [OUT_W-1:0]   pass_ff [3];
   logic signed [GT_W-1:0]    t0_in   [3];
   logic signed [GT_W-1:0]    t1_in   [3];
   logic [FRAC_BITS-1:0]      frac_in [3];
   logic                      below_in [3];
   logic signed [LIN_W-1:0]   lprod_in [3];

   // Second stage: interpolation product and saturated linear segment.
   logic signed [GT_W-1:0]    t0b_ff  [3];
   logic signed [IP_W-1:0]    ip_ff   [3];
   logic signed [OUT_W-1:0]   lseg_ff [3];
   logic                      belowb_ff [3];
   logic signed [OUT_W-1:0]   passb_ff [3];
   logic signed [IP_W-1:0]    ip_in   [3];
   logic signed [OUT_W-1:0]   lseg_in [3];

   // Output register.
   logic signed [OUT_W-1:0]   rgb_ff  [3];
   logic signed [OUT_W-1:0]   rgb_in  [3];

   // Clamp into [0, 1], locate the segment and read both ends.
   always_comb begin
      logic [FRAC_BITS:0]    vc;
      logic [POS_W-1:0]      pos;
      logic [GIDX_W-1:0]     idx;
      logic [GIDX_W-1:0]     idx1;
      for (int c = 0; c < 3; c++) begin
         if (lin_in[c] > ONE_S) begin
            vc = (FRAC_BITS + 1)'(ONE_FX);
         end else if (lin_in[c][OUT_W-1]) begin
            vc = '0;
         end else begin
            vc = lin_in[c][FRAC_BITS:0];
         end
         pos  = POS_W'(vc) * POS_W'(GAMMA_SEGMENTS);
         idx  = pos[POS_W-1:FRAC_BITS];
         idx1 = (idx >= LAST_IDX) ? LAST_IDX : idx + 1'b1;
         t0_in[c]    = GAMMA_TABLE[idx];
         t1_in[c]    = GAMMA_TABLE[idx1];
         frac_in[c]  = pos[FRAC_BITS-1:0];
         below_in[c] = (lin_in[c] <= THR_S);
         lprod_in[c] = lin_in[c] * C1292_S;
      end
   end

   // Interpolation product; the linear segment is rounded and saturated.
   always_comb begin
      logic signed [GT_W:0]      diff;
      logic signed [FRAC_BITS:0] fs;
      logic signed [LIN_W-1:0]   ls;
      for (int c = 0; c < 3; c++) begin
         diff      = (GT_W + 1)'(t1_ff[c]) - (GT_W + 1)'(t0_ff[c]);
         fs        = signed'({1'b0, frac_ff[c]});
         ip_in[c]  = diff * fs;
         ls        = (lprod_ff[c] + LIN_RND) >>> FRAC_BITS;
         if (ls > LIN_MAX) begin
            lseg_in[c] = OUT_W'(LIN_MAX);
         end else if (ls < LIN_MIN) begin
            lseg_in[c] = OUT_W'(LIN_MIN);
         end else begin
            lseg_in[c] = ls[OUT_W-1:0];
         end
      end
   end

   // Pick the result: zero on fault, linear if curve off, else segment or curve.
   always_comb begin
      logic signed [IP_W-1:0] step;
      for (int c = 0; c < 3; c++) begin
         step = (ip_ff[c] + IP_RND) >>> FRAC_BITS;
         if (flags_ff[1].fault) begin
            rgb_in[c] = '0;
         end else if (!flags_ff[1].gamma_en) begin
            rgb_in[c] = passb_ff[c];
         end else if (belowb_ff[c]) begin
            rgb_in[c] = lseg_ff[c];
         end else begin
            rgb_in[c] = OUT_W'(t0b_ff[c]) + OUT_W'(step);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < 3; s++) begin
            valid_ff[s] <= 1'b0;
         end
      end else if (ctl.advance) begin
         valid_ff[0] <= ctl.valid;
         valid_ff[1] <= valid_ff[0];
         valid_ff[2] <= valid_ff[1];
      end
      if (ctl.advance) begin
         flags_ff[0] <= flags_in;
         flags_ff[1] <= flags_ff[0];
         flags_ff[2] <= flags_ff[1];
         t0_ff     <= t0_in;
         t1_ff     <= t1_in;
         frac_ff   <= frac_in;
         below_ff  <= below_in;
         lprod_ff  <= lprod_in;
         pass_ff   <= lin_in;
         t0b_ff    <= t0_ff;
         ip_ff     <= ip_in;
         lseg_ff   <= lseg_in;
         belowb_ff <= below_ff;
         passb_ff  <= pass_ff;
         rgb_ff    <= rgb_in;
      end
   end

   assign valid_out = valid_ff[2];
   assign rgb_out   = rgb_ff;
   assign fault_out = flags_ff[2].fault;

   // The curve table is nondecreasing, so a segment never runs downward.
   `XYY2RGB_CHECK(a_gam_segment_order, clock, reset, valid_ff[0] |-> t0_ff[0] <= t1_ff[0] && t0_ff[1] <= t1_ff[1] && t0_ff[2] <= t1_ff[2])

endmodule

// ===== design/xyy_to_srgb_pixel_convert.sv =====
// Top level of the xyY / XYZ to sRGB pixel converter.
//
//   Channel   Direction  Handshake            Payload
//   req_chan  in         valid / ready        comp_a, comp_b, comp_c
//   rsp_chan  out        valid / ready        red_out, green_out, blue_out, divide_fault
//   csr_*     in         csr_wr_en            csr_index, csr_wdata
//
// One transaction per clock is accepted while the output is not held; each result
// passes one entry stage with the numerator multipliers, 37 divider stages, four
// matrix stages and three transfer-curve stages. The divider's one quotient bit
// per stage sets the depth. Reset is synchronous; it clears the valid bits and
// sets the two configuration registers to xyY input and gamma on. When a result
// is held at the output the whole pipeline holds; nothing is dropped or repeated.
`include "xyy_to_srgb_pixel_convert_defines.svh"
module xyy_to_srgb_pixel_convert
   import xyy2rgb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   xyy2rgb_req_if.sink           req_chan,
   xyy2rgb_rsp_if.source         rsp_chan,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int S_W = IN_W + 2;

   logic cfg_src_xyz_ff;
   logic cfg_gamma_ff;

   logic             advance;
   logic             entry_valid_ff;
   logic [NUM_W-1:0] entry_numx_ff;
   logic [NUM_W-1:0] entry_numz_ff;
   logic [IN_W-1:0]  entry_div_ff;
   side_type         entry_side_ff;
   logic [NUM_W-1:0] entry_numx_in;
   logic [NUM_W-1:0] entry_numz_in;
   logic [IN_W-1:0]  entry_div_in;
   side_type         entry_side_in;

   logic             div_valid;
   logic [NUM_W-1:0] div_qx;
   logic [NUM_W-1:0] div_qz;
   side_type         div_side;

   logic                    mtx_valid;
   logic signed [OUT_W-1:0] mtx_lin [3];
   flags_type               mtx_flags;

   logic                    gam_valid;
   logic signed [OUT_W-1:0] gam_rgb [3];
   logic                    gam_fault;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_src_xyz_ff <= 1'b0;
         cfg_gamma_ff   <= 1'b1;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_SOURCE_IS_XYZ: begin
               cfg_src_xyz_ff <= csr_wdata[0];
            end
            CSR_APPLY_GAMMA: begin
               cfg_gamma_ff <= csr_wdata[0];
            end
         endcase
      end
   end

   // The pipeline moves unless a finished result waits at the output.
   assign advance        = !gam_valid || rsp_chan.ready;
   assign req_chan.ready = advance;

   // Numerators for the divider. In XYZ mode the components pass through
   // as dividends over a divisor of one.
   always_comb begin
      logic signed [S_W-1:0] s;
      logic [IN_W:0]         s_mag;
      s     = S_W'(ONE_FX) - S_W'(req_chan.comp_a) - S_W'(req_chan.comp_b);
      s_mag = s[S_W-1] ? (IN_W + 1)'(-s) : s[IN_W:0];
      if (cfg_src_xyz_ff) begin
         entry_numx_in = NUM_W'(req_chan.comp_a);
         entry_numz_in = NUM_W'(req_chan.comp_c);
         entry_div_in  = IN_W'(1);
         entry_side_in = '{fault: 1'b0, gamma_en: cfg_gamma_ff, neg_z: 1'b0,
                           lum: req_chan.comp_b};
      end else begin
         entry_numx_in = NUM_W'(req_chan.comp_a) * NUM_W'(req_chan.comp_c);
         entry_numz_in = NUM_W'(s_mag) * NUM_W'(req_chan.comp_c);
         entry_div_in  = req_chan.comp_b;
         entry_side_in = '{fault: (req_chan.comp_b == '0), gamma_en: cfg_gamma_ff,
                           neg_z: s[S_W-1], lum: req_chan.comp_c};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= 1'b0;
      end else if (advance) begin
         entry_valid_ff <= req_chan.valid;
      end
      if (advance) begin
         entry_numx_ff <= entry_numx_in;
         entry_numz_ff <= entry_numz_in;
         entry_div_ff  <= entry_div_in;
         entry_side_ff <= entry_side_in;
      end
   end

   xyy2rgb_div u_div (
      .clock     (clock),
      .reset     (reset),
      .ctl       ('{advance: advance, valid: entry_valid_ff}),
      .num_x     (entry_numx_ff),
      .num_z     (entry_numz_ff),
      .divisor   (entry_div_ff),
      .side_in   (entry_side_ff),
      .valid_out (div_valid),
      .quot_x    (div_qx),
      .quot_z    (div_qz),
      .side_out  (div_side)
   );

   xyy2rgb_mtx u_mtx (
      .clock     (clock),
      .reset     (reset),
      .ctl       ('{advance: advance, valid: div_valid}),
      .quot_x    (div_qx),
      .quot_z    (div_qz),
      .side_in   (div_side),
      .valid_out (mtx_valid),
      .lin_out   (mtx_lin),
      .flags_out (mtx_flags)
   );

   xyy2rgb_gam u_gam (
      .clock     (clock),
      .reset     (reset),
      .ctl       ('{advance: advance, valid: mtx_valid}),
      .lin_in    (mtx_lin),
      .flags_in  (mtx_flags),
      .valid_out (gam_valid),
      .rgb_out   (gam_rgb),
      .fault_out (gam_fault)
   );

   assign rsp_chan.valid        = gam_valid;
   assign rsp_chan.red_out      = gam_rgb[0];
   assign rsp_chan.green_out    = gam_rgb[1];
   assign rsp_chan.blue_out     = gam_rgb[2];
   assign rsp_chan.divide_fault = gam_fault;

   // A faulted transaction carries zero colour.
   `XYY2RGB_ASSERT(a_fault_zero, clock, reset, rsp_chan.valid && rsp_chan.divide_fault |-> rsp_chan.red_out == '0 && rsp_chan.green_out == '0 && rsp_chan.blue_out == '0, "faulted result carries colour")

endmodule
